/* hw/rtl/cic_pkg.sv */
// Shared types and constants for the CPU interrupt controller.
package cic_pkg;

    localparam int unsigned NUM_SOURCES = 5;
    localparam int unsigned SRC_W       = 3;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned VECTOR_W    = 7;

    localparam int unsigned JOYPAD_SRC  = 4;

    localparam logic [VECTOR_W-1:0] VECTOR_BASE       = 7'h40;
    localparam logic [ADDR_W-1:0]   FLAG_ADDR_RESET   = 16'hFF0F;
    localparam logic [ADDR_W-1:0]   ENABLE_ADDR_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_RUN  = 2'd0,
        MODE_HALT = 2'd1,
        MODE_STOP = 2'd2
    } run_mode_t;

    typedef enum logic [2:0] {
        KIND_BUS_WRITE   = 3'd0,
        KIND_CHECK       = 3'd1,
        KIND_ENABLE_NEXT = 3'd2,
        KIND_DISABLE     = 3'd3,
        KIND_ENABLE_NOW  = 3'd4,
        KIND_HALT        = 3'd5,
        KIND_STOP        = 3'd6
    } event_kind_t;

    typedef enum logic {
        CFG_FLAG_ADDR   = 1'b0,
        CFG_ENABLE_ADDR = 1'b1
    } cfg_index_t;

endpackage

/* hw/rtl/cpu_interrupt_controller.sv */
// Top level of the five-source CPU interrupt controller.
// A result is valid in the cycle after its input transfer.
// Throughput: one item per cycle; the input stays ready while the result register is
// empty or is being drained in the same cycle.
// Reset: asynchronous, active low; flags, enables, master enable and the delayed enable
// clear, the run state returns to running and both bus addresses take their defaults.
module cpu_interrupt_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        kind,
    input  logic [cic_pkg::ADDR_W-1:0]        address,
    input  logic [cic_pkg::DATA_W-1:0]        value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              dispatch,
    output logic [cic_pkg::VECTOR_W-1:0]      vector,
    output logic [1:0]                        run_state,
    output logic                              master_enable,
    output logic [cic_pkg::NUM_SOURCES-1:0]   request_flags,
    output logic [cic_pkg::NUM_SOURCES-1:0]   enable_flags,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [cic_pkg::ADDR_W-1:0]        cfg_data
);
    import cic_pkg::*;

    logic [ADDR_W-1:0]      flag_addr_reg;
    logic [ADDR_W-1:0]      enable_addr_reg;
    logic [NUM_SOURCES-1:0] pending_reg, pending_next;
    logic [NUM_SOURCES-1:0] enabled_reg, enabled_next;
    logic                   ime_reg, ime_next;
    logic                   delayed_reg, delayed_next;
    run_mode_t              mode_reg, mode_next;
    logic                   out_valid_reg;
    logic                   dispatch_reg, dispatch_next;
    logic [VECTOR_W-1:0]    vector_reg, vector_next;

    logic                   in_fire;
    logic                   cfg_fire;
    event_kind_t            kind_code;
    logic [NUM_SOURCES-1:0] ready_src;
    logic [SRC_W-1:0]       src_sel;
    logic                   take_irq;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign kind_code = event_kind_t'(kind);
    assign ready_src = pending_reg & enabled_reg;

    always_comb
    begin
        src_sel = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            if (ready_src[i])
            begin
                src_sel = SRC_W'(i);
            end
        end
    end

    assign take_irq = (kind_code == KIND_CHECK) && (mode_reg != MODE_STOP) && ime_reg
                      && (ready_src != '0);

    // State update for one event.
    always_comb
    begin
        pending_next = pending_reg;
        enabled_next = enabled_reg;
        ime_next     = ime_reg;
        delayed_next = delayed_reg;
        mode_next    = mode_reg;
        case (kind_code)
            KIND_BUS_WRITE:
            begin
                if (address == flag_addr_reg)
                begin
                    pending_next = value[NUM_SOURCES-1:0];
                end
                else if (address == enable_addr_reg)
                begin
                    enabled_next = value[NUM_SOURCES-1:0];
                end
            end
            KIND_CHECK:
            begin
                if (mode_reg == MODE_STOP)
                begin
                    if (pending_reg[JOYPAD_SRC])
                    begin
                        mode_next = MODE_RUN;
                    end
                end
                else if ((mode_reg == MODE_HALT) && (ready_src != '0))
                begin
                    mode_next = MODE_RUN;
                end
                if (take_irq)
                begin
                    ime_next = 1'b0;
                    pending_next = pending_reg & ~(NUM_SOURCES'(1) << src_sel);
                end
                if (delayed_reg)
                begin
                    ime_next     = 1'b1;
                    delayed_next = 1'b0;
                end
            end
            KIND_ENABLE_NEXT:
            begin
                delayed_next = 1'b1;
            end
            KIND_DISABLE:
            begin
                ime_next     = 1'b0;
                delayed_next = 1'b0;
            end
            KIND_ENABLE_NOW:
            begin
                ime_next = 1'b1;
            end
            KIND_HALT:
            begin
                mode_next = MODE_HALT;
            end
            KIND_STOP:
            begin
                mode_next = MODE_STOP;
            end
            default:
            begin
            end
        endcase
    end

    // Result fields for one event.
    always_comb
    begin
        dispatch_next = take_irq;
        vector_next   = '0;
        if (take_irq)
        begin
            vector_next = VECTOR_BASE + {1'b0, src_sel, 3'b000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_addr_reg   <= FLAG_ADDR_RESET;
            enable_addr_reg <= ENABLE_ADDR_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FLAG_ADDR:   flag_addr_reg   <= cfg_data;
                CFG_ENABLE_ADDR: enable_addr_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            enabled_reg <= '0;
            ime_reg     <= 1'b0;
            delayed_reg <= 1'b0;
            mode_reg    <= MODE_RUN;
        end
        else if (in_fire)
        begin
            pending_reg <= pending_next;
            enabled_reg <= enabled_next;
            ime_reg     <= ime_next;
            delayed_reg <= delayed_next;
            mode_reg    <= mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dispatch_reg <= dispatch_next;
            vector_reg   <= vector_next;
        end
    end

    // State only moves on an input transfer, so it matches the held result.
    assign out_valid     = out_valid_reg;
    assign dispatch      = dispatch_reg;
    assign vector        = vector_reg;
    assign run_state     = mode_reg;
    assign master_enable = ime_reg;
    assign request_flags = pending_reg;
    assign enable_flags  = enabled_reg;

`ifndef ASSERT_OFF
    a_no_dispatch_without_ime: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !ime_reg) |=> !dispatch_reg)
        else $error("dispatch without master enable");

    a_dispatch_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dispatch_reg) |-> !pending_reg[vector_reg[5:3]])
        else $error("dispatched source flag still set");

    a_dispatch_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dispatch_reg) |-> (mode_reg == MODE_RUN))
        else $error("dispatch while not running");

    a_vector_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind_code != KIND_CHECK)) |=> (!dispatch_reg && (vector_reg == '0)))
        else $error("dispatch on a non-check event");
`endif

endmodule

/* bench/cpu_interrupt_controller_tb.sv */
// Self-checking testbench for the CPU interrupt controller with a built-in status predictor.
`timescale 1ns / 100ps

module cpu_interrupt_controller_tb;
    import cic_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 375;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]          kind;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   value;
    } bus_event_t;

    typedef struct packed {
        logic                   dispatch;
        logic [VECTOR_W-1:0]    vector;
        run_mode_t              run_state;
        logic                   master_enable;
        logic [NUM_SOURCES-1:0] request_flags;
        logic [NUM_SOURCES-1:0] enable_flags;
    } ctrl_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [2:0]             kind = '0;
    logic [ADDR_W-1:0]      address = '0;
    logic [DATA_W-1:0]      value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   dispatch;
    logic [VECTOR_W-1:0]    vector;
    logic [1:0]             run_state;
    logic                   master_enable;
    logic [NUM_SOURCES-1:0] request_flags;
    logic [NUM_SOURCES-1:0] enable_flags;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    bus_event_t   event_queue[$];
    ctrl_status_t status_due[$];
    int           events_unsent = 0;
    bit           event_taken = 1'b0;
    bit           reg_written = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_cycles = 0;
    int           mismatches = 0;
    int unsigned  cycle_count = 0;

    logic [ADDR_W-1:0]      flag_addr = FLAG_ADDR_RESET;
    logic [ADDR_W-1:0]      enab_addr = ENABLE_ADDR_RESET;
    logic [NUM_SOURCES-1:0] req_bits = '0;
    logic [NUM_SOURCES-1:0] enab_bits = '0;
    logic                   ime = 1'b0;
    logic                   ime_armed = 1'b0;
    run_mode_t              cpu_mode = MODE_RUN;

    cpu_interrupt_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .address       (address),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dispatch      (dispatch),
        .vector        (vector),
        .run_state     (run_state),
        .master_enable (master_enable),
        .request_flags (request_flags),
        .enable_flags  (enable_flags),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic ctrl_status_t step_controller(input bus_event_t ev);
        ctrl_status_t           s;
        logic [NUM_SOURCES-1:0] ready;
        logic [SRC_W-1:0]       n;
        s = '0;
        case (ev.kind)
            KIND_BUS_WRITE:
            begin
                if (ev.address == flag_addr)
                    req_bits = ev.value[NUM_SOURCES-1:0];
                else if (ev.address == enab_addr)
                    enab_bits = ev.value[NUM_SOURCES-1:0];
            end
            KIND_CHECK:
            begin
                ready = req_bits & enab_bits;
                if (cpu_mode == MODE_STOP)
                begin
                    if (req_bits[JOYPAD_SRC])
                        cpu_mode = MODE_RUN;
                end
                else if ((cpu_mode == MODE_HALT || ime) && ready != '0)
                begin
                    if (cpu_mode == MODE_HALT)
                        cpu_mode = MODE_RUN;
                    if (ime)
                    begin
                        n = '0;
                        while (!ready[n])
                            n++;
                        ime = 1'b0;
                        req_bits[n] = 1'b0;
                        s.dispatch = 1'b1;
                        s.vector = VECTOR_BASE + {1'b0, n, 3'b000};
                    end
                end
                if (ime_armed)
                begin
                    ime = 1'b1;
                    ime_armed = 1'b0;
                end
            end
            KIND_ENABLE_NEXT: ime_armed = 1'b1;
            KIND_DISABLE:
            begin
                ime = 1'b0;
                ime_armed = 1'b0;
            end
            KIND_ENABLE_NOW: ime = 1'b1;
            KIND_HALT: cpu_mode = MODE_HALT;
            KIND_STOP: cpu_mode = MODE_STOP;
            default: ;
        endcase
        s.run_state = cpu_mode;
        s.master_enable = ime;
        s.request_flags = req_bits;
        s.enable_flags = enab_bits;
        return s;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ctrl_status_t want;
        if (in_valid && in_ready)
        begin
            status_due.push_back(step_controller({kind, address, value}));
            events_unsent--;
            event_taken = 1'b1;
        end
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FLAG_ADDR)
                flag_addr = cfg_data;
            else
                enab_addr = cfg_data;
            reg_written = 1'b1;
        end
        if (out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transfer with no status waiting", $time);
            end
            else
            begin
                want = status_due.pop_front();
                check_field("dispatch", int'(want.dispatch), int'(dispatch));
                check_field("vector", int'(want.vector), int'(vector));
                check_field("run_state", int'(want.run_state), int'(run_state));
                check_field("master_enable", int'(want.master_enable), int'(master_enable));
                check_field("request_flags", int'(want.request_flags), int'(request_flags));
                check_field("enable_flags", int'(want.enable_flags), int'(enable_flags));
            end
        end
    end

    always @(negedge clk)
    begin
        bus_event_t ev;
        if (!in_valid || event_taken)
        begin
            event_taken = 1'b0;
            if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                ev = event_queue.pop_front();
                in_valid <= 1'b1;
                kind <= ev.kind;
                address <= ev.address;
                value <= ev.value;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_event(input logic [2:0] k, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
        event_queue.push_back({k, a, d});
        events_unsent++;
    endtask

    task automatic push_random_event();
        int unsigned r;
        logic [DATA_W-1:0] d;
        r = $urandom_range(99);
        d = DATA_W'($urandom_range(255));
        if (r < 22)
            push_event(KIND_BUS_WRITE, flag_addr, d);
        else if (r < 36)
            push_event(KIND_BUS_WRITE, enab_addr, d);
        else if (r < 42)
            push_event(KIND_BUS_WRITE, ADDR_W'($urandom_range(65535)), d);
        else if (r < 70)
            push_event(KIND_CHECK, ADDR_W'($urandom_range(65535)), d);
        else if (r < 77)
            push_event(KIND_ENABLE_NEXT, ADDR_W'($urandom_range(65535)), d);
        else if (r < 81)
            push_event(KIND_DISABLE, ADDR_W'($urandom_range(65535)), d);
        else if (r < 88)
            push_event(KIND_ENABLE_NOW, ADDR_W'($urandom_range(65535)), d);
        else if (r < 94)
            push_event(KIND_HALT, ADDR_W'($urandom_range(65535)), d);
        else if (r < 98)
            push_event(KIND_STOP, ADDR_W'($urandom_range(65535)), d);
        else
            push_event(KIND_UNUSED, ADDR_W'($urandom_range(65535)), d);
    endtask

    task automatic wait_idle();
        while (events_unsent != 0 || status_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ADDR_W-1:0] data);
        reg_written = 1'b0;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(negedge clk);
        while (!reg_written);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] fa, input logic [ADDR_W-1:0] ea,
                             input int send_pct, input int recv_pct, input int hold);
        int sent;
        int batch;
        write_reg(CFG_FLAG_ADDR, fa);
        write_reg(CFG_ENABLE_ADDR, ea);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hold_cycles = hold;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            batch = $urandom_range(60, 20);
            repeat (batch)
                push_random_event();
            sent += batch;
            wait_idle();
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] shared_addr;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_event(KIND_BUS_WRITE, ENABLE_ADDR_RESET, 8'hFF);
        push_event(KIND_BUS_WRITE, FLAG_ADDR_RESET, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_ENABLE_NOW, 16'h0000, 8'h00);
        push_event(KIND_BUS_WRITE, FLAG_ADDR_RESET, 8'hFF);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_ENABLE_NEXT, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_ENABLE_NEXT, 16'h0000, 8'h00);
        push_event(KIND_DISABLE, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_ENABLE_NOW, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_HALT, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_STOP, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_BUS_WRITE, FLAG_ADDR_RESET, 8'h10);
        push_event(KIND_ENABLE_NEXT, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_BUS_WRITE, 16'h0000, 8'hAA);
        push_event(KIND_UNUSED, 16'hFFFF, 8'hFF);
        push_event(KIND_HALT, 16'h0000, 8'h00);
        push_event(KIND_CHECK, 16'h0000, 8'h00);
        push_event(KIND_BUS_WRITE, ENABLE_ADDR_RESET, 8'h00);
        push_event(KIND_STOP, 16'h0000, 8'h00);
        push_event(KIND_HALT, 16'h0000, 8'h00);
        wait_idle();

        shared_addr = ADDR_W'($urandom_range(65535));
        run_phase(FLAG_ADDR_RESET, ENABLE_ADDR_RESET, 0, 0, 300);
        run_phase(16'h0000, 16'hFFFF, 65, 0, 0);
        run_phase(16'hFFFF, 16'h0000, 0, 65, 0);
        run_phase(shared_addr, shared_addr, 38, 38, 0);
        run_phase(ADDR_W'($urandom_range(65535)), ADDR_W'($urandom_range(65535)), 0, 0, 0);

        wait_idle();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
